// ===== rtl/pwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_pkg
// shared constants for the polygon window clipper
// ----------------------------------------------------------------------------
package pwc_pkg;

  // default widths
  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 12;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 2'd3;

  // boundary stage codes, the last one means "emit"
  localparam int STG_BITS = 3;
  localparam logic [STG_BITS-1:0] STG_LEFT   = 3'd0;
  localparam logic [STG_BITS-1:0] STG_RIGHT  = 3'd1;
  localparam logic [STG_BITS-1:0] STG_BOTTOM = 3'd2;
  localparam logic [STG_BITS-1:0] STG_TOP    = 3'd3;
  localparam logic [STG_BITS-1:0] STG_EMIT   = 3'd4;

  localparam int NUM_STAGES = 4;

  // pending work stack
  localparam int STACK_DEPTH = 8;
  localparam int STACK_IDX   = 3;

  // input and output queue depths
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;

endpackage

// ===== rtl/pwc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_fifo
// small synchronous queue with full and empty flags
// ----------------------------------------------------------------------------
module pwc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pwc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_engine
// back end: walks one vertex through the four boundary stages, closes the
// polygon on the final vertex, and writes result beats to the output queue
// ----------------------------------------------------------------------------
module pwc_engine #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // window
  input  logic [COORD_BITS-1:0] win_x_min,
  input  logic [COORD_BITS-1:0] win_y_min,
  input  logic [COORD_BITS-1:0] win_x_max,
  input  logic [COORD_BITS-1:0] win_y_max,
  // input queue side
  input  logic                  in_empty,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic                  in_final,
  output logic                  in_pop,
  // output queue side
  input  logic                  out_full,
  output logic                  out_push,
  output logic [2*COORD_BITS+COUNT_BITS+2:0] out_data
);
  import pwc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + 1;
  localparam int PW = 2 * CW;
  localparam int NW = $clog2(PW + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_VISIT, S_CLOSE, S_MUL, S_NORM, S_DIV, S_FIN, S_FLUSH
  } state_t;

  state_t state;

  // work stack of (point, stage)
  logic [CB-1:0]       stk_x  [STACK_DEPTH];
  logic [CB-1:0]       stk_y  [STACK_DEPTH];
  logic [STG_BITS-1:0] stk_st [STACK_DEPTH];
  logic [STACK_IDX:0]  sp;
  logic [STACK_IDX-1:0] top_idx;
  logic [STACK_IDX-1:0] push_idx;

  // per stage memory
  logic [CB-1:0] first_x [NUM_STAGES];
  logic [CB-1:0] first_y [NUM_STAGES];
  logic [CB-1:0] prev_x  [NUM_STAGES];
  logic [CB-1:0] prev_y  [NUM_STAGES];
  logic [NUM_STAGES-1:0] first_valid;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_inc;

  // item control
  logic          fin;
  logic [2:0]    cst;

  // held result, flagged once the step ends
  logic                  have_pend;
  logic [CB-1:0]         pend_x;
  logic [CB-1:0]         pend_y;
  logic [COUNT_BITS-1:0] pend_cnt;

  // intersection unit
  logic [CW-1:0]       ea;
  logic [CW-1:0]       eb;
  logic [CW-1:0]       ed;
  logic [CB-1:0]       base;
  logic [CB-1:0]       edge_c;
  logic                xstage;
  logic [STG_BITS-1:0] ist;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       num;
  logic [CW:0]         rem;
  logic [CW:0]         quo;
  logic [CW-1:0]       dmag;
  logic                neg;
  logic [NW-1:0]       cnt;

  // combinational views
  logic [CB-1:0]       cur_x;
  logic [CB-1:0]       cur_y;
  logic [STG_BITS-1:0] cur_st;
  logic [1:0]          cur_si;
  logic [1:0]          cl_si;
  logic                cur_in;
  logic                prv_in;
  logic                cl_prev_in;
  logic                cl_first_in;
  logic [CB-1:0]       s1x, s1y, s2x, s2y;
  logic [1:0]          s_si;
  logic [CB-1:0]       s_edge;
  logic [CW:0]         rem_sh;
  logic                qbit;
  logic [CW:0]         rem_nx;
  logic [CW:0]         sum;
  logic [CB-1:0]       res;

  function automatic logic inside_f(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                    input logic [1:0] si,
                                    input logic [CB-1:0] xmin, input logic [CB-1:0] xmax,
                                    input logic [CB-1:0] ymin, input logic [CB-1:0] ymax);
    logic r;
    unique case (si)
      STG_LEFT[1:0]:   r = $signed(x) >= $signed(xmin);
      STG_RIGHT[1:0]:  r = $signed(x) <= $signed(xmax);
      STG_BOTTOM[1:0]: r = $signed(y) >= $signed(ymin);
      default:         r = $signed(y) <= $signed(ymax);
    endcase
    return r;
  endfunction

  assign top_idx  = STACK_IDX'(sp - 1'b1);
  assign push_idx = sp[STACK_IDX-1:0];
  assign cur_x    = stk_x[top_idx];
  assign cur_y    = stk_y[top_idx];
  assign cur_st   = stk_st[top_idx];
  assign cur_si   = cur_st[1:0];
  assign cl_si    = cst[1:0];
  assign count_inc = (count == CNT_MAX) ? count : count + 1'b1;

  // inside tests for a stage visit and a closing edge
  assign cur_in = inside_f(cur_x, cur_y, cur_si, win_x_min, win_x_max, win_y_min, win_y_max);
  assign prv_in = inside_f(prev_x[cur_si], prev_y[cur_si], cur_si,
                           win_x_min, win_x_max, win_y_min, win_y_max);
  assign cl_prev_in  = inside_f(prev_x[cl_si], prev_y[cl_si], cl_si,
                                win_x_min, win_x_max, win_y_min, win_y_max);
  assign cl_first_in = inside_f(first_x[cl_si], first_y[cl_si], cl_si,
                                win_x_min, win_x_max, win_y_min, win_y_max);

  // edge endpoints for the intersection setup; p2 is the base point
  always_comb begin
    if (state == S_CLOSE) begin
      s1x  = prev_x[cl_si];
      s1y  = prev_y[cl_si];
      s2x  = first_x[cl_si];
      s2y  = first_y[cl_si];
      s_si = cl_si;
    end else begin
      s1x  = cur_x;
      s1y  = cur_y;
      s2x  = prev_x[cur_si];
      s2y  = prev_y[cur_si];
      s_si = cur_si;
    end
    case (s_si)
      STG_LEFT[1:0]:   s_edge = win_x_min;
      STG_RIGHT[1:0]:  s_edge = win_x_max;
      STG_BOTTOM[1:0]: s_edge = win_y_min;
      default:         s_edge = win_y_max;
    endcase
  end

  // one restoring divide step
  always_comb begin
    rem_sh = {rem[CW-1:0], num[PW-1]};
    qbit   = (rem_sh >= {1'b0, dmag});
    rem_nx = qbit ? rem_sh - {1'b0, dmag} : rem_sh;
    sum    = {{2{base[CB-1]}}, base} + (neg ? -quo : quo);
    res    = sum[CB-1:0];
  end

  // queue handshakes and result beat
  always_comb begin
    in_pop   = (state == S_IDLE) && !in_empty;
    out_push = 1'b0;
    out_data = {pend_x, pend_y, 1'b1, 1'b0, 1'b0, pend_cnt};
    if (state == S_VISIT && sp != '0 && cur_st == STG_EMIT && have_pend) begin
      out_push = !out_full;
    end else if (state == S_FLUSH) begin
      if (have_pend) begin
        out_push = !out_full;
        out_data = {pend_x, pend_y, 1'b1, 1'b1, fin, pend_cnt};
      end else if (fin) begin
        out_push = !out_full;
        out_data = {{CB{1'b0}}, {CB{1'b0}}, 1'b0, 1'b1, 1'b1, count};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sp          <= '0;
      first_valid <= '0;
      count       <= '0;
      have_pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!in_empty) begin
            stk_x[0]  <= in_x;
            stk_y[0]  <= in_y;
            stk_st[0] <= STG_LEFT;
            sp        <= (STACK_IDX+1)'(1);
            fin       <= in_final;
            cst       <= '0;
            have_pend <= 1'b0;
            state     <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (sp == '0) begin
            state <= (fin && cst != 3'(NUM_STAGES)) ? S_CLOSE : S_FLUSH;
          end else if (cur_st == STG_EMIT) begin
            if (!have_pend || !out_full) begin
              pend_x    <= cur_x;
              pend_y    <= cur_y;
              pend_cnt  <= count_inc;
              count     <= count_inc;
              have_pend <= 1'b1;
              sp        <= sp - 1'b1;
            end
          end else begin
            // stage visit: record first, detect crossing, update previous
            if (!first_valid[cur_si]) begin
              first_x[cur_si]     <= cur_x;
              first_y[cur_si]     <= cur_y;
              first_valid[cur_si] <= 1'b1;
            end else if (cur_in != prv_in) begin
              state <= S_MUL;
            end
            prev_x[cur_si] <= cur_x;
            prev_y[cur_si] <= cur_y;
            if (cur_in) begin
              stk_st[top_idx] <= cur_st + 1'b1;
            end else begin
              sp <= sp - 1'b1;
            end
            ist <= cur_st + 1'b1;
          end
          // intersection operands, used only when a crossing starts
          xstage <= !s_si[1];
          edge_c <= s_edge;
          if (!s_si[1]) begin
            ea   <= {s_edge[CB-1], s_edge} - {s2x[CB-1], s2x};
            eb   <= {s1y[CB-1], s1y} - {s2y[CB-1], s2y};
            ed   <= {s1x[CB-1], s1x} - {s2x[CB-1], s2x};
            base <= s2y;
          end else begin
            ea   <= {s_edge[CB-1], s_edge} - {s2y[CB-1], s2y};
            eb   <= {s1x[CB-1], s1x} - {s2x[CB-1], s2x};
            ed   <= {s1y[CB-1], s1y} - {s2y[CB-1], s2y};
            base <= s2x;
          end
        end
        S_CLOSE: begin
          // closing edge of one stage: previous to first
          cst    <= cst + 1'b1;
          ist    <= {1'b0, cl_si} + 1'b1;
          xstage <= !s_si[1];
          edge_c <= s_edge;
          if (!s_si[1]) begin
            ea   <= {s_edge[CB-1], s_edge} - {s2x[CB-1], s2x};
            eb   <= {s1y[CB-1], s1y} - {s2y[CB-1], s2y};
            ed   <= {s1x[CB-1], s1x} - {s2x[CB-1], s2x};
            base <= s2y;
          end else begin
            ea   <= {s_edge[CB-1], s_edge} - {s2y[CB-1], s2y};
            eb   <= {s1x[CB-1], s1x} - {s2x[CB-1], s2x};
            ed   <= {s1y[CB-1], s1y} - {s2y[CB-1], s2y};
            base <= s2x;
          end
          if (first_valid[cl_si] && cl_prev_in != cl_first_in) begin
            state <= S_MUL;
          end else begin
            state <= S_VISIT;
          end
        end
        S_MUL: begin
          prod  <= PW'($signed(ea) * $signed(eb));
          state <= S_NORM;
        end
        S_NORM: begin
          num   <= prod[PW-1] ? -prod : prod;
          dmag  <= ed[CW-1] ? -ed : ed;
          neg   <= prod[PW-1] ^ ed[CW-1];
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_nx;
          quo <= {quo[CW-1:0], qbit};
          num <= {num[PW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == NW'(PW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // crossing point goes on top of the stack
          stk_x[push_idx]  <= xstage ? edge_c : res;
          stk_y[push_idx]  <= xstage ? res : edge_c;
          stk_st[push_idx] <= ist;
          sp               <= sp + 1'b1;
          state            <= S_VISIT;
        end
        S_FLUSH: begin
          if (have_pend || fin) begin
            if (!out_full) begin
              have_pend <= 1'b0;
              if (fin) begin
                first_valid <= '0;
                count       <= '0;
              end
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/polygon_window_clipper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_window_clipper_core
// clips a polygon, one vertex per beat, against an axis-aligned window
// ----------------------------------------------------------------------------
// Usage:
//   vertices go in through push/full; a beat is taken when push is high and
//   full is low. final_vertex on a beat closes the polygon.
//   results come out through empty/pop; the oldest result sits on the ports
//   while empty is low and leaves on a clock with pop high.
//   the window registers are written through cfg_we/cfg_index/cfg_data; the
//   user writes them only while the block is idle, the block does not enforce it.
// Flow:
//   a 4-deep input queue takes vertices while the clip engine works.
//   a vertex is dropped at a boundary stage or passes all four stages and is
//   emitted; each edge crossing goes through the shared multiply and
//   bit-serial divide unit.
//   a result is held until the next one or the end of its vertex is known,
//   then enters the output queue and reaches the ports behind older results.
// Reset: rst clears queues, stage memory, count and the window to defaults.
// Stall: a full output queue holds the engine; the input queue then fills
//   and full rises.
// ----------------------------------------------------------------------------
module polygon_window_clipper_core #(
  parameter int COORD_BITS = pwc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pwc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [pwc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  // vertex input
  input  logic                            push,
  output logic                            full,
  input  logic [COORD_BITS-1:0]           vertex_x,
  input  logic [COORD_BITS-1:0]           vertex_y,
  input  logic                            final_vertex,
  // result output
  output logic                            empty,
  input  logic                            pop,
  output logic [COORD_BITS-1:0]           out_x,
  output logic [COORD_BITS-1:0]           out_y,
  output logic                            has_vertex,
  output logic                            run_last,
  output logic                            polygon_done,
  output logic [COUNT_BITS-1:0]           vertex_count
);
  import pwc_pkg::*;

  localparam int IW = 2 * COORD_BITS + 1;
  localparam int OW = 2 * COORD_BITS + COUNT_BITS + 3;

  logic [COORD_BITS-1:0] win_x_min;
  logic [COORD_BITS-1:0] win_y_min;
  logic [COORD_BITS-1:0] win_x_max;
  logic [COORD_BITS-1:0] win_y_max;

  logic [IW-1:0]         in_rdata;
  logic                  in_empty;
  logic                  in_pop;
  logic                  out_full;
  logic                  out_push;
  logic [OW-1:0]         out_wdata;
  logic [OW-1:0]         out_rdata;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_min <= '0;
      win_y_min <= '0;
      win_x_max <= {1'b0, {(COORD_BITS-1){1'b1}}};
      win_y_max <= {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN: win_x_min <= cfg_data;
        REG_Y_MIN: win_y_min <= cfg_data;
        REG_X_MAX: win_x_max <= cfg_data;
        default:   win_y_max <= cfg_data;
      endcase
    end
  end

  // front: vertex queue
  pwc_fifo #(.WIDTH(IW), .DEPTH(IN_DEPTH)) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({final_vertex, vertex_x, vertex_y}),
    .full  (full),
    .pop   (in_pop),
    .rdata (in_rdata),
    .empty (in_empty)
  );

  // back: clip engine
  pwc_engine #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .win_x_min (win_x_min),
    .win_y_min (win_y_min),
    .win_x_max (win_x_max),
    .win_y_max (win_y_max),
    .in_empty  (in_empty),
    .in_x      (in_rdata[2*COORD_BITS-1:COORD_BITS]),
    .in_y      (in_rdata[COORD_BITS-1:0]),
    .in_final  (in_rdata[IW-1]),
    .in_pop    (in_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  // result queue
  pwc_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_x        = out_rdata[OW-1:OW-COORD_BITS];
  assign out_y        = out_rdata[OW-COORD_BITS-1:COUNT_BITS+3];
  assign has_vertex   = out_rdata[COUNT_BITS+2];
  assign run_last     = out_rdata[COUNT_BITS+1];
  assign polygon_done = out_rdata[COUNT_BITS];
  assign vertex_count = out_rdata[COUNT_BITS-1:0];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the polygon window clipper core
// ----------------------------------------------------------------------------
// Vertices go in through the push/full queue port and results come out
// through the empty/pop port. A behavioral clipper inside the bench predicts
// every output vertex. Each popped beat is compared field by field with the
// oldest prediction. Window registers are rewritten between polygons, only
// after the core has drained. The phases cover directed polygons, window
// extremes, a zigzag through a narrow slab, a long receiver hold-off and
// random polygons.
// ----------------------------------------------------------------------------
module tb_top;
  import pwc_pkg::*;

  localparam int CW = 16;
  localparam int NW = 12;
  localparam int CNT_MAX = (1 << NW) - 1;
  localparam int MAX_PER_VERTEX = 32;
  localparam int DRAIN_CYCLES = 4000;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          has;
    logic          last;
    logic          done;
    logic [NW-1:0] cnt;
  } clip_vertex_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic push, full;
  logic [CW-1:0] vertex_x, vertex_y;
  logic final_vertex;
  logic empty, pop;
  logic [CW-1:0] out_x, out_y;
  logic has_vertex, run_last, polygon_done;
  logic [NW-1:0] vertex_count;

  polygon_window_clipper_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .final_vertex(final_vertex),
    .empty(empty), .pop(pop),
    .out_x(out_x), .out_y(out_y), .has_vertex(has_vertex),
    .run_last(run_last), .polygon_done(polygon_done),
    .vertex_count(vertex_count)
  );

  // predicted clipper state
  longint win_lo_x, win_lo_y, win_hi_x, win_hi_y;
  longint first_x [NUM_STAGES];
  longint first_y [NUM_STAGES];
  longint prev_x [NUM_STAGES];
  longint prev_y [NUM_STAGES];
  bit     first_seen [NUM_STAGES];
  int     poly_count;

  clip_vertex_t vertex_beats[$];   // beats of the vertex being predicted
  clip_vertex_t pending_vertices[$];

  int  errors;
  int  send_idle_pct, recv_idle_pct;
  int  holdoff_cycles;
  longint cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("polygon_window_clipper_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic bit in_bound(longint px, longint py, int st);
    case (st)
      0: return px >= win_lo_x;
      1: return px <= win_hi_x;
      2: return py >= win_lo_y;
      default: return py <= win_hi_y;
    endcase
  endfunction

  function automatic longint scale_div(longint a, longint b, longint d);
    if (d == 0) return 0;
    return (a * b) / d;
  endfunction

  function automatic void push_beat(longint px, longint py, bit has);
    clip_vertex_t v;
    if (vertex_beats.size() >= MAX_PER_VERTEX) return;
    if (has && poly_count < CNT_MAX) poly_count++;
    v.x = has ? px[CW-1:0] : '0;
    v.y = has ? py[CW-1:0] : '0;
    v.has = has;
    v.last = 1'b0;
    v.done = 1'b0;
    v.cnt = poly_count[NW-1:0];
    vertex_beats.push_back(v);
  endfunction

  // crossing of edge p1 -> p2 with the boundary of stage st, based at p2
  function automatic void cross_point(longint x1, longint y1, longint x2, longint y2,
                                      int st, output longint rx, output longint ry);
    longint e;
    if (st < 2) begin
      e = (st == 0) ? win_lo_x : win_hi_x;
      rx = e;
      ry = y2 + scale_div(e - x2, y1 - y2, x1 - x2);
    end else begin
      e = (st == 2) ? win_lo_y : win_hi_y;
      ry = e;
      rx = x2 + scale_div(e - y2, x1 - x2, y1 - y2);
    end
  endfunction

  function automatic void hand_on(longint px, longint py, int st);
    if (st < 3) clip_stage(px, py, st + 1);
    else push_beat(px, py, 1'b1);
  endfunction

  function automatic void clip_stage(longint px, longint py, int st);
    longint ix, iy;
    if (!first_seen[st]) begin
      first_x[st] = px;
      first_y[st] = py;
      first_seen[st] = 1'b1;
    end else if (in_bound(px, py, st) != in_bound(prev_x[st], prev_y[st], st)) begin
      cross_point(px, py, prev_x[st], prev_y[st], st, ix, iy);
      hand_on(ix, iy, st);
    end
    prev_x[st] = px;
    prev_y[st] = py;
    if (in_bound(px, py, st)) hand_on(px, py, st);
  endfunction

  function automatic void predict_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, bit fin);
    longint px, py, ix, iy;
    px = longint'($signed(vx));
    py = longint'($signed(vy));
    vertex_beats.delete();
    clip_stage(px, py, 0);
    if (fin) begin
      // closing edges, previous vertex to first vertex
      for (int st = 0; st < NUM_STAGES; st++) begin
        if (first_seen[st] &&
            in_bound(prev_x[st], prev_y[st], st) != in_bound(first_x[st], first_y[st], st))
        begin
          cross_point(prev_x[st], prev_y[st], first_x[st], first_y[st], st, ix, iy);
          hand_on(ix, iy, st);
        end
      end
      if (vertex_beats.size() == 0) push_beat(px, py, 1'b0);
      vertex_beats[vertex_beats.size()-1].done = 1'b1;
      for (int st = 0; st < NUM_STAGES; st++) first_seen[st] = 1'b0;
      poly_count = 0;
    end
    if (vertex_beats.size() > 0) vertex_beats[vertex_beats.size()-1].last = 1'b1;
    foreach (vertex_beats[i]) pending_vertices.push_back(vertex_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  initial begin
    clip_vertex_t want;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        pop = 1'b0;
        holdoff_cycles--;
      end else begin
        pop = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (pop && !empty && !rst) begin
        if (pending_vertices.size() == 0) begin
          $error("unexpected result beat x=%0h y=%0h", out_x, out_y);
          errors++;
        end else begin
          want = pending_vertices.pop_front();
          if (out_x !== want.x) begin
            $error("out_x expected %0h got %0h", want.x, out_x); errors++;
          end
          if (out_y !== want.y) begin
            $error("out_y expected %0h got %0h", want.y, out_y); errors++;
          end
          if (has_vertex !== want.has) begin
            $error("has_vertex expected %0b got %0b", want.has, has_vertex); errors++;
          end
          if (run_last !== want.last) begin
            $error("run_last expected %0b got %0b", want.last, run_last); errors++;
          end
          if (polygon_done !== want.done) begin
            $error("polygon_done expected %0b got %0b", want.done, polygon_done); errors++;
          end
          if (vertex_count !== want.cnt) begin
            $error("vertex_count expected %0d got %0d", want.cnt, vertex_count); errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_vertex(longint vx, longint vy, int fin);
    bit taken;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    vertex_x = vx[CW-1:0];
    vertex_y = vy[CW-1:0];
    final_vertex = (fin != 0);
    taken = 1'b0;
    // full only moves on a rising edge, so its value here holds for the edge
    while (!taken) begin
      taken = !full;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end
    predict_vertex(vx[CW-1:0], vy[CW-1:0], fin != 0);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    // vertices that clip to nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_X_MIN: win_lo_x = longint'($signed(value[CW-1:0]));
      REG_Y_MIN: win_lo_y = longint'($signed(value[CW-1:0]));
      REG_X_MAX: win_hi_x = longint'($signed(value[CW-1:0]));
      default:   win_hi_y = longint'($signed(value[CW-1:0]));
    endcase
  endtask

  task automatic set_window(longint x0, longint y0, longint x1, longint y1);
    drain();
    write_reg(REG_X_MIN, x0);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_X_MAX, x1);
    write_reg(REG_Y_MAX, y1);
  endtask

  function automatic logic [CW-1:0] rand_coord(longint lo, longint hi);
    longint c, span;
    // mostly near the window, sometimes anywhere
    if ($urandom_range(9) < 2) return CW'($urandom);
    span = (hi > lo ? hi - lo : lo - hi) + 64;
    c = (lo < hi ? lo : hi) - span / 2 + longint'($urandom_range(2 * span));
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c[CW-1:0];
  endfunction

  task automatic send_polygon(int n);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(win_lo_x, win_hi_x), rand_coord(win_lo_y, win_hi_y),
                  int'(i == n - 1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    set_window(-100, -100, 100, 100);
    // square fully inside
    send_vertex(-50, -50, 0);
    send_vertex(50, -50, 0);
    send_vertex(50, 50, 0);
    send_vertex(-50, 50, 1);
    // triangle crossing left and top
    send_vertex(-300, 0, 0);
    send_vertex(50, 0, 0);
    send_vertex(0, 400, 1);
    // fully outside: empty closing beat
    send_vertex(500, 500, 0);
    send_vertex(600, 500, 0);
    send_vertex(600, 700, 1);
    // single vertex, inside then outside
    send_vertex(0, 0, 1);
    send_vertex(-32768, 32767, 1);
    // coordinate extremes around the window
    send_vertex(-32768, -32768, 0);
    send_vertex(32767, -32768, 0);
    send_vertex(32767, 32767, 0);
    send_vertex(-32768, 32767, 1);
    // polygon left of the window that never passes the left stage
    send_vertex(-200, 0, 0);
    send_vertex(-150, 30, 0);
    send_vertex(-120, -20, 1);
  endtask

  task automatic test_window_extremes();
    // full range window
    set_window(-32768, -32768, 32767, 32767);
    send_vertex(-32768, -32768, 0);
    send_vertex(32767, 0, 0);
    send_vertex(0, 32767, 1);
    // inverted window
    set_window(100, 100, -100, -100);
    send_vertex(-200, 0, 0);
    send_vertex(200, 0, 0);
    send_vertex(0, 200, 1);
    // zero-size window on the most negative corner
    set_window(-32768, -32768, -32768, -32768);
    send_vertex(-32768, 5, 0);
    send_vertex(40, -32768, 0);
    send_vertex(32767, 32767, 1);
  endtask

  task automatic test_slab_zigzag();
    // each jump across a narrow slab gives two output vertices
    set_window(-10, -32768, 10, 32767);
    for (int i = 0; i < 20; i++)
      send_vertex((i % 2) ? 1000 : -1000, i * 7, int'(i == 19));
  endtask

  task automatic test_backpressure();
    set_window(-1000, -1000, 1000, 1000);
    holdoff_cycles = 1500;
    for (int i = 0; i < 12; i++)
      send_vertex(longint'($urandom_range(1) ? 1500 : -1500), rand_coord(-1000, 1000),
                  int'(i == 11));
  endtask

  task automatic test_random(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        set_window(longint'($signed(CW'($urandom))), longint'($signed(CW'($urandom))),
                   longint'($signed(CW'($urandom))), longint'($signed(CW'($urandom))));
      end else if ($urandom_range(4) == 0) begin
        len = $urandom_range(400, 2);
        set_window(-len, -len / 2, len, len * 2);
      end
      len = $urandom_range(8, 1);
      send_polygon(len);
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    holdoff_cycles = 0;
    send_idle_pct = 31;
    recv_idle_pct = 84;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_X_MIN;
    cfg_data = '0;
    push = 1'b0;
    vertex_x = '0;
    vertex_y = '0;
    final_vertex = 1'b0;
    win_lo_x = 0;
    win_lo_y = 0;
    win_hi_x = 32767;
    win_hi_y = 32767;
    poly_count = 0;
    for (int st = 0; st < NUM_STAGES; st++) first_seen[st] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default window straight out of reset
    send_vertex(-5, 10, 0);
    send_vertex(20, 20, 0);
    send_vertex(20, -8, 1);

    test_directed();
    test_window_extremes();
    test_random(10);

    send_idle_pct = 84;
    recv_idle_pct = 31;
    test_backpressure();
    test_random(10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_slab_zigzag();
    test_random(10);

    drain();
    if (errors == 0)
      $display("polygon_window_clipper_core regression: pass");
    else
      $display("polygon_window_clipper_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pwc_pkg.sv
rtl/pwc_fifo.sv
rtl/pwc_engine.sv
rtl/polygon_window_clipper_core.sv
test/tb_top.sv
